// ===== hdl/netmask_text_parser_top_macros.svh =====
// ----------------------------------------------------------------------------
// Netmask text parser assertion macros
// Shared assertion wrappers, clocked on clk_i with an active low reset.
// ----------------------------------------------------------------------------
`ifndef NETMASK_TEXT_PARSER_TOP_MACROS_SVH
`define NETMASK_TEXT_PARSER_TOP_MACROS_SVH

// check that is masked while reset is applied
`define NTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also holds during reset
`define NTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/ntp_pkg.sv =====
// ----------------------------------------------------------------------------
// Netmask text parser package
// Types, character codes and reset state shared by the parser files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ntp_pkg;

  // result classes
  typedef enum logic [1:0] {
    KIND_HOST = 2'd0,
    KIND_V4   = 2'd1,
    KIND_V6   = 2'd2
  } kind_e;

  // character codes
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [3:0] NO_GAP     = 4'd15;
  localparam logic [2:0] HEX_DIGITS = 3'd4;
  localparam int unsigned V6_BITS   = 128;
  localparam int unsigned V4_BITS   = 32;
  localparam int unsigned HEXTET_W  = 16;
  localparam int unsigned OCTET_W   = 8;

  typedef struct packed {
    logic start;
    logic v4bad;
    logic v6bad;
    logic slash;
    logic star;
    logic dot;
    logic colon;
  } flags_t;

  typedef struct packed {
    logic [3:0][7:0]  oct;
    logic [1:0]       dots;
    logic [7:0][15:0] hext;
    logic [2:0]       hidx;
    logic [2:0]       dleft;
    logic [3:0]       gap;
    logic [7:0]       pfx;
    logic [7:0]       prev;
    flags_t           fl;
  } state_t;

  localparam state_t ST_RESET = '{
    oct:   '0,
    dots:  '0,
    hext:  '0,
    hidx:  '0,
    dleft: HEX_DIGITS,
    gap:   NO_GAP,
    pfx:   '0,
    prev:  '0,
    fl:    '{start: 1'b1, default: 1'b0}
  };

  // decimal digit test
  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // hex digit test, value in low nibble
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'h00;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
        t = c - 8'h30;
        return {1'b1, t[3:0]};
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
        t = c - 8'h37;
        return {1'b1, t[3:0]};
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
        t = c - 8'h57;
        return {1'b1, t[3:0]};
      end
      return 5'd0;
    end
  endfunction

endpackage

// ===== hdl/ntp_in_if.sv =====
// ----------------------------------------------------------------------------
// Netmask text parser input channel
// One character beat with a last-character flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ntp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, ch, last, input ready);
  modport sink (input valid, ch, last, output ready);
endinterface

// ===== hdl/ntp_out_if.sv =====
// ----------------------------------------------------------------------------
// Netmask text parser output channel
// One parsed mask beat: class, address and prefix length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ntp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [7:0]  prefix_len;

  modport source (output valid, kind, addr_high, addr_low, prefix_len, input ready);
  modport sink (input valid, kind, addr_high, addr_low, prefix_len, output ready);
endinterface

// ===== hdl/netmask_text_parser_top.sv =====
// ----------------------------------------------------------------------------
// Netmask text parser
// Parses IPv4 / IPv6 mask text one character per beat and emits class,
// address and prefix length on the last character.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  in_i    | in  | ch, last
//  out_o   | out | kind, addr_high, addr_low, prefix_len
//
// one character per cycle while no result is stalled on out_o
// pipeline: input register, parse state update, final snapshot, result register
// the whole pipeline stalls together while a result waits on out_o.ready
// reset clears all valid flags and the parse state; no clearing pass needed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "netmask_text_parser_top_macros.svh"

module netmask_text_parser_top
  import ntp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  ntp_in_if.sink        in_i,
  ntp_out_if.source     out_o
);

  logic       en;
  logic       in_v_q;
  logic [7:0] in_ch_q;
  logic       in_last_q;
  state_t     st_q, st_d, nx;
  logic       snap_v_q;
  state_t     snap_q;
  logic       out_v_q;
  logic [1:0] kind_q, kind_d;
  logic [63:0] hi_q, hi_d, lo_q, lo_d;
  logic [7:0] plen_q, plen_d;

  // global advance
  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_i.valid) begin
      in_ch_q   <= in_i.ch;
      in_last_q <= in_i.last;
    end
  end

  // per-character state update
  always_comb begin
    logic [4:0]  hv;
    logic        dig;
    logic [11:0] pv;
    logic [7:0]  ov;
    logic [2:0]  k;
    logic [2:0]  dl;
    nx  = st_q;
    hv  = hex_val(in_ch_q);
    dig = is_dec(in_ch_q);
    pv  = '0;
    ov  = '0;
    k   = st_q.hidx;
    dl  = '0;
    if (in_ch_q == CH_DOT) nx.fl.dot = 1'b1;
    if (in_ch_q == CH_COLON) nx.fl.colon = 1'b1;
    if (st_q.fl.slash) begin
      if (dig) begin
        pv = {4'd0, st_q.pfx} * 12'd10 + {8'd0, hv[3:0]};
        nx.pfx = (pv > 12'd255) ? 8'd255 : pv[7:0];
      end else begin
        nx.fl.v4bad = 1'b1;
        nx.fl.v6bad = 1'b1;
      end
    end else begin
      // ipv4 side
      if (!st_q.fl.v4bad) begin
        if (dig) begin
          ov = st_q.oct[st_q.dots];
          nx.oct[st_q.dots] = 8'((ov << 3) + (ov << 1) + {4'd0, hv[3:0]});
        end else if (in_ch_q == CH_DOT) begin
          if (st_q.dots == 2'd3) nx.fl.v4bad = 1'b1;
          else nx.dots = st_q.dots + 2'd1;
        end else if (in_ch_q == CH_STAR) begin
          if (!in_last_q || st_q.dots == 2'd0 || st_q.prev != CH_DOT) nx.fl.v4bad = 1'b1;
        end else if (in_ch_q != CH_SLASH) begin
          nx.fl.v4bad = 1'b1;
        end
      end
      // ipv6 side
      if (!st_q.fl.v6bad) begin
        if (hv[4]) begin
          if (st_q.dleft == 3'd0 || st_q.dleft > HEX_DIGITS) begin
            nx.fl.v6bad = 1'b1;
          end else begin
            dl = st_q.dleft - 3'd1;
            nx.dleft = dl;
            nx.hext[k] = st_q.hext[k] | (16'(hv[3:0]) << {dl, 2'b00});
          end
        end else if (in_ch_q == CH_COLON) begin
          if (!st_q.fl.start && st_q.prev == CH_COLON) begin
            if (st_q.gap != NO_GAP) nx.fl.v6bad = 1'b1;
            else nx.gap = {1'b0, k};
          end else begin
            dl = (st_q.dleft > HEX_DIGITS) ? HEX_DIGITS : st_q.dleft;
            nx.hext[k] = st_q.hext[k] >> {dl, 2'b00};
            nx.dleft = HEX_DIGITS;
            if (k == 3'd7) nx.fl.v6bad = 1'b1;
            else nx.hidx = k + 3'd1;
          end
        end else if (in_ch_q == CH_STAR) begin
          if (st_q.gap != NO_GAP || !in_last_q || k == 3'd0 || st_q.prev != CH_COLON)
            nx.fl.v6bad = 1'b1;
        end else if (in_ch_q != CH_SLASH) begin
          nx.fl.v6bad = 1'b1;
        end
      end
      if (in_ch_q == CH_STAR) nx.fl.star = 1'b1;
      if (in_ch_q == CH_SLASH) nx.fl.slash = 1'b1;
    end
    nx.prev     = in_ch_q;
    nx.fl.start = 1'b0;
    st_d = in_last_q ? ST_RESET : nx;
  end

  // parse state and final snapshot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_RESET;
      snap_v_q <= 1'b0;
    end else if (en) begin
      snap_v_q <= in_v_q && in_last_q;
      if (in_v_q) st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_v_q && in_last_q) snap_q <= nx;
  end

  // result assembly from the snapshot
  always_comb begin
    logic [2:0]       n4;
    logic [5:0]       b4;
    logic [31:0]      a4;
    logic [7:0][15:0] d;
    logic [7:0][15:0] dc;
    logic [2:0]       nyb;
    logic [2:0]       dp;
    logic [3:0]       dpe;
    logic [7:0]       b6;
    logic [7:0]       lim;
    logic [3:0]       ceil16;
    logic signed [4:0] def;
    logic             gap_ok;
    logic             rej6;
    logic [4:0]       j;
    logic [7:0]       keep;
    kind_d     = KIND_HOST;
    hi_d       = '0;
    lo_d       = '0;
    plen_d     = '0;
    n4  = {1'b0, snap_q.dots} + 3'd1;
    b4  = '0;
    a4  = {snap_q.oct[0], snap_q.oct[1], snap_q.oct[2], snap_q.oct[3]};
    d   = snap_q.hext;
    dc  = '0;
    nyb = (snap_q.dleft > HEX_DIGITS) ? HEX_DIGITS : snap_q.dleft;
    dp  = snap_q.hidx;
    dpe = {1'b0, dp};
    b6  = '0;
    lim = {1'b0, dp, 4'd0} + {3'd0, 3'(HEX_DIGITS - nyb), 2'd0};
    gap_ok = !snap_q.gap[3];
    rej6 = 1'b0;
    j    = '0;
    keep = '0;
    ceil16 = '0;
    def    = '0;
    d[dp] = d[dp] >> {nyb, 2'b00};
    if (snap_q.fl.dot) begin
      if (!snap_q.fl.v4bad) begin
        if (snap_q.fl.slash) begin
          if (snap_q.pfx > {2'd0, n4, 3'd0}) begin
            n4 = 3'd0;
          end else begin
            b4 = snap_q.pfx[5:0];
          end
        end else if (snap_q.fl.star) begin
          b4 = {1'b0, snap_q.dots, 3'd0};
        end
        if (!(snap_q.fl.slash && snap_q.pfx > {2'd0, snap_q.dots + 2'd1 == 2'd0 ?
              3'd4 : {1'b0, snap_q.dots + 2'd1}, 3'd0})) begin
          if (b4 == 6'd0) b4 = {n4, 3'd0};
          kind_d = KIND_V4;
          lo_d   = {32'd0, a4 & ~(32'hFFFF_FFFF >> b4)};
          plen_d = {2'd0, b4};
        end
      end
    end else if (snap_q.fl.colon && !snap_q.fl.v6bad) begin
      if (snap_q.fl.slash) begin
        if (snap_q.pfx > 8'(V6_BITS)) rej6 = 1'b1;
        if (!gap_ok && snap_q.pfx > lim) rej6 = 1'b1;
        b6 = snap_q.pfx;
      end else if (snap_q.fl.star) begin
        b6  = {1'b0, dp, 4'd0};
        dpe = {1'b0, dp} + 4'd1;
      end else begin
        b6  = 8'(V6_BITS);
        dpe = {1'b0, dp} + 4'd1;
      end
      if (!gap_ok && b6 == 8'd0) b6 = {dpe, 4'd0};
      ceil16 = 4'((b6 + 8'd15) >> 4);
      def = $signed({1'b0, ceil16}) - $signed({1'b0, dpe});
      // insert zero hextets at the gap
      for (int i = 0; i < 8; i++) begin
        if (gap_ok && 4'(i) >= snap_q.gap) begin
          if (def < 0) begin
            dc[i] = '0;
          end else if ({1'b0, 4'(i)} < {1'b0, snap_q.gap} + def) begin
            dc[i] = '0;
          end else begin
            j = 5'(i) - def;
            dc[i] = d[j[2:0]];
          end
        end else begin
          dc[i] = d[i];
        end
      end
      // clear bits past the prefix
      for (int i = 0; i < 8; i++) begin
        keep = (b6 > 8'(HEXTET_W * i)) ? b6 - 8'(HEXTET_W * i) : 8'd0;
        if (keep < 8'(HEXTET_W))
          dc[i] = dc[i] & ~(16'hFFFF >> keep[4:0]);
      end
      if (!rej6) begin
        kind_d = KIND_V6;
        hi_d   = {dc[0], dc[1], dc[2], dc[3]};
        lo_d   = {dc[4], dc[5], dc[6], dc[7]};
        plen_d = b6;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= snap_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && snap_v_q) begin
      kind_q <= kind_d;
      hi_q   <= hi_d;
      lo_q   <= lo_d;
      plen_q <= plen_d;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.kind       = kind_q;
  assign out_o.addr_high  = hi_q;
  assign out_o.addr_low   = lo_q;
  assign out_o.prefix_len = plen_q;

  // checks
  `NTP_ASSERT(a_host_zero, out_v_q && kind_q == KIND_HOST |-> hi_q == '0 && lo_q == '0 && plen_q == '0, "hostname beat carries data")
  `NTP_ASSERT(a_v4_shape, out_v_q && kind_q == KIND_V4 |-> hi_q == '0 && lo_q[63:32] == '0 && plen_q <= 8'(V4_BITS), "bad ipv4 beat")
  `NTP_ASSERT(a_v6_len, out_v_q && kind_q == KIND_V6 |-> plen_q <= 8'(V6_BITS), "ipv6 prefix too long")
  `NTP_ASSERT(a_state_clear, en && in_v_q && in_last_q |=> st_q == ST_RESET, "state not cleared after last")
  `NTP_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !out_v_q && !snap_v_q, "valid set after reset")

endmodule

// ===== tb/sv/netmask_text_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// Netmask text parser testbench
// Streams IPv4, IPv6, hostname and corrupted mask texts into the parser with
// random gaps and output stalls, predicts every parsed mask in a scoreboard
// and compares class, address and prefix length field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module netmask_text_parser_top_tb;
  import ntp_pkg::*;

  typedef struct {
    kind_e      kind;
    bit [63:0]  hi;
    bit [63:0]  lo;
    bit [7:0]   plen;
  } mask_res_t;

  // scoreboard: mirrors the parse state and queues predicted masks
  class mask_scoreboard;
    bit [7:0]    oct[4];
    int          dots;
    bit [15:0]   hext[8];
    int          hidx, dleft, gap, pfx;
    bit [7:0]    prev;
    bit          f_start, f_v4bad, f_v6bad, f_slash, f_star, f_dot, f_colon;
    mask_res_t   masks_q[$];
    int          errors, n_texts, n_v4, n_v6, n_host;

    function new();
      clear_text();
    endfunction

    function void clear_text();
      foreach (oct[i]) oct[i] = '0;
      foreach (hext[i]) hext[i] = '0;
      dots = 0; hidx = 0; dleft = 4; gap = 15; pfx = 0; prev = '0;
      f_start = 1; f_v4bad = 0; f_v6bad = 0; f_slash = 0; f_star = 0;
      f_dot = 0; f_colon = 0;
    endfunction

    function mask_res_t finish_v4();
      mask_res_t r;
      int n, bits;
      bit [31:0] a, m;
      r = '{KIND_HOST, '0, '0, '0};
      n = dots + 1;
      bits = 0;
      if (f_slash) begin
        if (pfx > n * 8) return r;
        bits = pfx;
      end else if (f_star) begin
        bits = dots * 8;
      end
      if (bits == 0) bits = n * 8;
      a = {oct[0], oct[1], oct[2], oct[3]};
      m = (bits >= 32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> bits);
      r.kind = KIND_V4;
      r.lo = {32'h0, a & m};
      r.plen = bits[7:0];
      return r;
    endfunction

    function mask_res_t finish_v6();
      mask_res_t r;
      bit [15:0] d[8], dc[8];
      int dp, nyb, gp, bits, deficit, src, keep;
      r = '{KIND_HOST, '0, '0, '0};
      dp = hidx;
      nyb = (dleft > 4) ? 4 : dleft;
      gp = (gap < 8) ? gap : -1;
      d = hext;
      d[dp] = d[dp] >> (4 * nyb);
      if (f_slash) begin
        if (pfx > 128) return r;
        if (gp < 0 && pfx > dp * 16 + (4 - nyb) * 4) return r;
        bits = pfx;
      end else if (f_star) begin
        bits = dp * 16;
        dp++;
      end else begin
        bits = 128;
        dp++;
      end
      if (gp < 0 && bits == 0) bits = dp * 16;
      deficit = (bits + 15) / 16 - dp;
      // expand the gap with zero hextets
      src = 0;
      for (int i = 0; i < 8; i++) begin
        if (src == gp && deficit != 0) begin
          dc[i] = '0;
          deficit--;
        end else begin
          dc[i] = (src < 8) ? d[src] : 16'h0;
          src++;
        end
      end
      for (int i = 0; i < 8; i++) begin
        keep = bits - 16 * i;
        if (keep < 0) keep = 0;
        dc[i] &= (keep >= 16) ? 16'hFFFF : ~(16'hFFFF >> keep);
      end
      r.kind = KIND_V6;
      r.hi = {dc[0], dc[1], dc[2], dc[3]};
      r.lo = {dc[4], dc[5], dc[6], dc[7]};
      r.plen = bits[7:0];
      return r;
    endfunction

    // one accepted character beat
    function void note_char(bit [7:0] c, bit last);
      int hv, k, nyb, v;
      bit dig;
      mask_res_t r;
      dig = (c >= "0" && c <= "9");
      if (dig) hv = c - "0";
      else if (c >= "A" && c <= "F") hv = c - "A" + 10;
      else if (c >= "a" && c <= "f") hv = c - "a" + 10;
      else hv = -1;
      if (c == CH_DOT) f_dot = 1;
      if (c == CH_COLON) f_colon = 1;
      if (f_slash) begin
        if (dig) begin
          v = pfx * 10 + (c - "0");
          pfx = (v > 255) ? 255 : v;
        end else begin
          f_v4bad = 1;
          f_v6bad = 1;
        end
      end else begin
        // dotted decimal side
        if (!f_v4bad) begin
          if (dig) oct[dots] = oct[dots] * 8'd10 + (c - "0");
          else if (c == CH_DOT) begin
            if (dots >= 3) f_v4bad = 1;
            else dots++;
          end else if (c == CH_STAR) begin
            if (!last || dots == 0 || prev != CH_DOT) f_v4bad = 1;
          end else if (c != CH_SLASH) f_v4bad = 1;
        end
        // hextet side
        if (!f_v6bad) begin
          k = hidx;
          if (hv >= 0) begin
            if (dleft == 0 || dleft > 4) f_v6bad = 1;
            else begin
              dleft--;
              hext[k] |= 16'(hv) << (4 * dleft);
            end
          end else if (c == CH_COLON) begin
            if (!f_start && prev == CH_COLON) begin
              if (gap != 15) f_v6bad = 1;
              else gap = k;
            end else begin
              nyb = (dleft > 4) ? 4 : dleft;
              hext[k] = hext[k] >> (4 * nyb);
              dleft = 4;
              if (k >= 7) f_v6bad = 1;
              else hidx = k + 1;
            end
          end else if (c == CH_STAR) begin
            if (gap != 15 || !last || k == 0 || prev != CH_COLON) f_v6bad = 1;
          end else if (c != CH_SLASH) f_v6bad = 1;
        end
        if (c == CH_STAR) f_star = 1;
        if (c == CH_SLASH) f_slash = 1;
      end
      prev = c;
      f_start = 0;
      if (last) begin
        r = '{KIND_HOST, '0, '0, '0};
        if (f_dot) begin
          if (!f_v4bad) r = finish_v4();
        end else if (f_colon) begin
          if (!f_v6bad) r = finish_v6();
        end
        masks_q.push_back(r);
        n_texts++;
        clear_text();
      end
    endfunction

    function void check_mask(bit [1:0] kind, bit [63:0] hi, bit [63:0] lo, bit [7:0] plen);
      mask_res_t e;
      if (masks_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected mask beat kind=%0d", kind);
        return;
      end
      e = masks_q.pop_front();
      case (kind)
        KIND_V4: n_v4++;
        KIND_V6: n_v6++;
        default: n_host++;
      endcase
      if (kind != e.kind || hi != e.hi || lo != e.lo || plen != e.plen) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: mask mismatch exp kind=%0d hi=%h lo=%h len=%0d, got kind=%0d hi=%h lo=%h len=%0d",
                   e.kind, e.hi, e.lo, e.plen, kind, hi, lo, plen);
      end
    endfunction

    function int pending();
      return masks_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ntp_in_if  in_if ();
  ntp_out_if out_if ();

  netmask_text_parser_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  mask_scoreboard sb = new();
  bit             no_idle;
  bit             drained;
  int             n_chars;
  int             quiet_cycles;
  byte unsigned   text_q[$];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // result sink with random stalls
  initial begin
    int stall;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready)
        sb.check_mask(out_if.kind, out_if.addr_high, out_if.addr_low, out_if.prefix_len);
      if (stall == 0) stall = pick_gap();
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else if (rst_ni) quiet_cycles++;
      if (quiet_cycles >= 2000) begin
        $display("ERROR: watchdog expired with %0d masks outstanding", sb.pending());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // drive the characters in text_q, last flag on the final one
  task automatic send_text();
    int g;
    for (int i = 0; i < text_q.size(); i++) begin
      g = pick_gap();
      if (g > 0) begin
        in_if.valid <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      in_if.valid <= 1'b1;
      in_if.ch    <= text_q[i];
      in_if.last  <= (i == text_q.size() - 1);
      do @(posedge clk_i); while (!in_if.ready);
      sb.note_char(text_q[i], i == text_q.size() - 1);
      n_chars++;
    end
    text_q.delete();
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  function automatic string rand_hextet();
    string hexd, s;
    hexd = "0123456789abcdefABCDEF";
    s = "";
    repeat ($urandom_range(1, 4)) s = {s, string'(hexd[$urandom_range(0, 21)])};
    return s;
  endfunction

  function automatic string rand_prefix(int top);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return "/";
    if (r == 1) return $sformatf("/%0d", $urandom_range(200, 99999));
    return $sformatf("/%0d", $urandom_range(0, top));
  endfunction

  function automatic string rand_v4();
    string s;
    int n;
    n = $urandom_range(1, 4);
    s = "";
    for (int i = 0; i < n; i++) begin
      if (i > 0) s = {s, "."};
      s = {s, $sformatf("%0d", ($urandom_range(0, 9) == 0) ? $urandom_range(256, 999)
                                                           : $urandom_range(0, 255))};
    end
    if (n < 4 && n > 1 && $urandom_range(0, 3) == 0) s = {s, ".*"};
    else if ($urandom_range(0, 1)) s = {s, rand_prefix(40)};
    return s;
  endfunction

  function automatic string rand_v6();
    string s;
    int n, g;
    n = $urandom_range(1, 8);
    g = -1;
    if (n < 8 && $urandom_range(0, 2) == 0) g = $urandom_range(0, n);
    s = "";
    for (int i = 0; i <= n; i++) begin
      if (i == g) s = {s, "::"};
      else if (i > 0 && i < n) s = {s, ":"};
      if (i < n) s = {s, rand_hextet()};
    end
    if (g < 0 && n < 8 && $urandom_range(0, 3) == 0) s = {s, ":*"};
    else if ($urandom_range(0, 1)) s = {s, rand_prefix(135)};
    return s;
  endfunction

  // main sequence
  initial begin
    string directed[$];
    string s;
    int r;
    n_chars = 0;
    no_idle = 1'b0;
    drained = 1'b0;
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.ch    <= 8'h00;
    in_if.last  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed texts: extremes, stars, gaps, prefixes, rejects
    directed = '{"10.1.2.3", "255.255.255.255/32", "192.168.1.0/24", "10.1.*", "1.*",
                 "10.1/0", "10.1/", "10.0.0.0/40", "300.1.2.3/99999", "1.2.3.4.5",
                 "::1", "fe80::/10", "2001:DB8::/32", "2001:db8:*", "::*", "*",
                 "1:2:3:4:5:6:7:8", "1:2:3:4:5:6:7:8:9", "1::2::3", ":::",
                 "abcd:12/20", "ffff::/129", "host-name", "1.2/x", "a:b.c"};
    foreach (directed[i]) send_str(directed[i]);
    text_q.push_back(8'h00);
    send_text();
    text_q.push_back(8'hFF);
    send_text();

    // random texts, mostly well formed
    while (n_chars < 1850) begin
      if (n_chars > 900 && n_chars < 1100) no_idle = 1'b1;
      else no_idle = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 42) s = rand_v4();
      else if (r < 84) s = rand_v6();
      else s = "";
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      if (s.len() == 0)
        repeat ($urandom_range(1, 6)) text_q.push_back($urandom_range(0, 255));
      else if ($urandom_range(0, 9) == 0)
        text_q[$urandom_range(0, text_q.size() - 1)] = $urandom_range(0, 255);
      send_text();
      // hold off once until the parser has drained
      if (!drained && n_chars > 600) begin
        drained = 1'b1;
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d texts over %0d characters with random gaps and output stalls",
             sb.n_texts, n_chars);
    $display("Masks seen: %0d IPv4, %0d IPv6, %0d hostname or rejected; %0d mismatches",
             sb.n_v4, sb.n_v6, sb.n_host, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ntp_pkg.sv
hdl/ntp_in_if.sv
hdl/ntp_out_if.sv
hdl/netmask_text_parser_top.sv
tb/sv/netmask_text_parser_top_tb.sv
